@@ rtl/isolated_peak_clip_filter_top_macros.svh @@
// assertion macros for the isolated peak clip filter rtl
`ifndef ISOLATED_PEAK_CLIP_FILTER_TOP_MACROS_SVH
`define ISOLATED_PEAK_CLIP_FILTER_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// checked on every clock edge outside reset
`define IPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
// checked on every clock edge, reset included
`define IPC_ASSERT_NR(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("assertion failed");
`else
`define IPC_ASSERT(lbl, prop)
`define IPC_ASSERT_NR(lbl, prop)
`endif

`endif

@@ rtl/ipc_pkg.sv @@
// shared constants and types of the isolated peak clip filter
`default_nettype none

package ipc_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned PIX_W      = 16;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned WID_W      = 11;
  localparam int unsigned HGT_W      = 16;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [WID_W-1:0] RESET_WIDTH  = WID_W'(MAX_WIDTH);
  localparam logic [HGT_W-1:0] RESET_HEIGHT = HGT_W'(768);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } cfg_idx_e;

  typedef enum logic {
    KIND_PIXEL,
    KIND_DRAIN
  } kind_e;

  // effective frame geometry and a restart strobe
  typedef struct packed {
    logic [WID_W-1:0] width;
    logic [HGT_W-1:0] height;
    logic             restart;
  } cfg_t;

  // line buffer write and read request
  typedef struct packed {
    logic             we_center;
    logic             we_upper;
    logic [COL_W-1:0] waddr;
    logic [PIX_W-1:0] center_wdata;
    logic [PIX_W-1:0] upper_wdata;
    logic [COL_W-1:0] raddr;
  } lb_req_t;

  // registered line buffer read data
  typedef struct packed {
    logic [PIX_W-1:0] center;
    logic [PIX_W-1:0] right;
    logic [PIX_W-1:0] upper;
  } lb_rd_t;

endpackage

`default_nettype wire

@@ rtl/ipc_cfg.sv @@
// configuration registers with width and height clamping
`default_nettype none

module ipc_cfg import ipc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [WID_W-1:0] width_q, width_d, wr_width;
  logic [HGT_W-1:0] height_q, height_d, wr_height;

  always_comb begin
    wr_width  = cfg_data_i[WID_W-1:0];
    wr_height = cfg_data_i[HGT_W-1:0];
    width_d   = width_q;
    height_d  = height_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH: begin
          if (wr_width == '0) begin
            width_d = WID_W'(1);
          end else if (wr_width > WID_W'(MAX_WIDTH)) begin
            width_d = WID_W'(MAX_WIDTH);
          end else begin
            width_d = wr_width;
          end
        end
        REG_FRAME_HEIGHT: begin
          height_d = (wr_height == '0) ? HGT_W'(1) : wr_height;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= RESET_WIDTH;
      height_q <= RESET_HEIGHT;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
    end
  end

  assign cfg_o.width   = width_q;
  assign cfg_o.height  = height_q;
  assign cfg_o.restart = cfg_we_i;

endmodule

`default_nettype wire

@@ rtl/ipc_line_buf.sv @@
// upper and center line stores with registered, write-first reads
`default_nettype none

module ipc_line_buf import ipc_pkg::*; (
  input  wire logic clk_i,
  input  lb_req_t   req_i,
  output lb_rd_t    rd_o
);

  logic [PIX_W-1:0] center_mem [MAX_WIDTH];
  logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];

  logic [PIX_W-1:0] center_q, right_q, upper_q;
  logic [COL_W-1:0] raddr_next;

  assign raddr_next = req_i.raddr + COL_W'(1);

  always_ff @(posedge clk_i) begin
    if (req_i.we_center) begin
      center_mem[req_i.waddr] <= req_i.center_wdata;
    end
    if (req_i.we_upper) begin
      upper_mem[req_i.waddr] <= req_i.upper_wdata;
    end
    // bypass covers narrow frames where the next column is the one just written
    if (req_i.we_center && req_i.waddr == req_i.raddr) begin
      center_q <= req_i.center_wdata;
    end else begin
      center_q <= center_mem[req_i.raddr];
    end
    if (req_i.we_center && req_i.waddr == raddr_next) begin
      right_q <= req_i.center_wdata;
    end else begin
      right_q <= center_mem[raddr_next];
    end
    if (req_i.we_upper && req_i.waddr == req_i.raddr) begin
      upper_q <= req_i.upper_wdata;
    end else begin
      upper_q <= upper_mem[req_i.raddr];
    end
  end

  assign rd_o.center = center_q;
  assign rd_o.right  = right_q;
  assign rd_o.upper  = upper_q;

endmodule

`default_nettype wire

@@ rtl/ipc_ctrl.sv @@
// input register, raster counters, peak test and result register
`default_nettype none
`include "isolated_peak_clip_filter_top_macros.svh"

module ipc_ctrl import ipc_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_valid_i,
  output logic                  s_ready_o,
  input  wire logic             s_kind_i,
  input  wire logic [PIX_W-1:0] s_pixel_i,
  output logic                  m_valid_o,
  input  wire logic             m_ready_i,
  output logic [PIX_W-1:0]      m_pixel_o,
  output logic                  m_replaced_o,
  output logic                  m_eor_o,
  output logic                  m_eof_o,
  input  cfg_t                  cfg_i,
  output lb_req_t               lb_req_o,
  input  lb_rd_t                lb_rd_i
);

  function automatic logic [PIX_W-1:0] pmax(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  logic             in_valid_q, in_valid_d;
  kind_e            in_kind_q;
  logic [PIX_W-1:0] in_pixel_q;

  logic             out_valid_q, out_valid_d;
  logic [PIX_W-1:0] out_pixel_q;
  logic             out_rep_q, out_eor_q, out_eof_q;

  logic [COL_W-1:0] col_q, col_d;
  logic [HGT_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] left_q, left_d;

  logic             out_free, advance, is_pixel, drain_phase;
  logic             take_pixel, take_drain, emit, last_col;
  logic [WID_W-1:0] col_inc;
  logic             has_up, has_down, has_left, has_right, any_nb, peak, replaced;
  logic [PIX_W-1:0] cur, up_v, down_v, left_v, right_v, nb_max, result;

  assign out_free  = !out_valid_q || m_ready_i;
  assign advance   = in_valid_q && out_free;
  assign s_ready_o = !in_valid_q || out_free;

  always_comb begin
    col_inc     = WID_W'(col_q) + WID_W'(1);
    last_col    = col_inc >= cfg_i.width;
    drain_phase = row_q >= cfg_i.height;
    is_pixel    = in_kind_q == KIND_PIXEL;
    take_pixel  = advance && is_pixel && !drain_phase;
    take_drain  = advance && !is_pixel && drain_phase;
    emit        = (take_pixel && row_q != '0) || take_drain;

    // window around the center pixel; absent neighbours count as zero
    cur       = lb_rd_i.center;
    has_up    = is_pixel ? (row_q > HGT_W'(1)) : (cfg_i.height > HGT_W'(1));
    has_down  = is_pixel;
    has_left  = col_q != '0;
    has_right = !last_col;
    up_v      = has_up    ? lb_rd_i.upper : '0;
    down_v    = has_down  ? in_pixel_q    : '0;
    left_v    = has_left  ? left_q        : '0;
    right_v   = has_right ? lb_rd_i.right : '0;
    any_nb    = has_up || has_down || has_left || has_right;
    peak      = (!has_up || up_v < cur) && (!has_down || down_v < cur) &&
                (!has_left || left_v < cur) && (!has_right || right_v < cur);
    nb_max    = pmax(pmax(up_v, down_v), pmax(left_v, right_v));
    replaced  = any_nb && peak;
    result    = replaced ? nb_max : cur;

    col_d  = col_q;
    row_d  = row_q;
    left_d = left_q;
    if (cfg_i.restart) begin
      col_d  = '0;
      row_d  = '0;
      left_d = '0;
    end else if (take_pixel) begin
      if (row_q != '0) begin
        left_d = cur;
      end
      if (last_col) begin
        col_d = '0;
        row_d = row_q + HGT_W'(1);
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end else if (take_drain) begin
      left_d = cur;
      if (last_col) begin
        col_d = '0;
        row_d = '0;
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end

    in_valid_d  = s_ready_o ? s_valid_i : in_valid_q;
    out_valid_d = advance ? emit : (out_valid_q && !m_ready_i);
  end

  assign lb_req_o.we_center    = take_pixel;
  assign lb_req_o.we_upper     = take_pixel && row_q != '0;
  assign lb_req_o.waddr        = col_q;
  assign lb_req_o.center_wdata = in_pixel_q;
  assign lb_req_o.upper_wdata  = cur;
  assign lb_req_o.raddr        = col_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      left_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      col_q       <= col_d;
      row_q       <= row_d;
      left_q      <= left_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      in_kind_q  <= kind_e'(s_kind_i);
      in_pixel_q <= s_pixel_i;
    end
    if (advance && emit) begin
      out_pixel_q <= result;
      out_rep_q   <= replaced;
      out_eor_q   <= last_col;
      out_eof_q   <= take_drain && last_col;
    end
  end

  assign m_valid_o    = out_valid_q;
  assign m_pixel_o    = out_pixel_q;
  assign m_replaced_o = out_rep_q;
  assign m_eor_o      = out_eor_q;
  assign m_eof_o      = out_eof_q;

  `IPC_ASSERT(a_col_in_frame, WID_W'(col_q) < cfg_i.width)
  `IPC_ASSERT(a_row_in_frame, row_q <= cfg_i.height)
  `IPC_ASSERT(a_eof_has_eor, out_valid_q && out_eof_q |-> out_eor_q)
  `IPC_ASSERT(a_drain_wraps, take_drain && last_col |=> row_q == '0 && col_q == '0)
  `IPC_ASSERT_NR(a_reset_empty, !rst_ni |-> !out_valid_q && !in_valid_q)

endmodule

`default_nettype wire

@@ rtl/isolated_peak_clip_filter_top.sv @@
// Isolated peak clip filter: 4-neighbour hot pixel removal on a raster stream.
// s_axis carries one beat per pixel (tuser[0] = 0) or drain tick (tuser[0] = 1);
// m_axis carries filtered pixels in raster order, tlast on the last pixel of a row.
// A pixel strictly above all of its in-frame up/down/left/right neighbours is
// replaced by the largest of them; frame width and height come from the cfg port,
// and a cfg write restarts the frame (write only while the block is idle).
// A pixel's result leaves when the pixel below it arrives, so output trails input
// by one row; after the last row, one drain beat per pixel flushes that row.
// Path: a beat accepted from s_axis is held in the input register, where one pass
// through the line buffer read data and peak compare forms its result, which loads
// the result register once that register is free. One beat per cycle sustained
// while m_axis_tready is high: the line buffers take one write and their reads
// each cycle.
// Reset: frame 1024 x 768, counters at the first pixel, outputs empty; line
// buffer contents are undefined but never used before written.
// When m_axis_tready is low the result register holds and the input register
// still takes one more beat; s_axis_tready falls only when both are full.
`default_nettype none

module isolated_peak_clip_filter_top import ipc_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,  // [15:0] pixel_in
  input  wire logic [0:0]            s_axis_tuser,  // [0] kind
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [15:0] pixel_out
  output logic [1:0]                 m_axis_tuser,  // [0] was_replaced, [1] end_of_frame
  output logic                       m_axis_tlast,  // end_of_row
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  lb_req_t lb_req;
  lb_rd_t  lb_rd;
  logic    replaced, eof;

  ipc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  ipc_line_buf u_line_buf (
    .clk_i (clk_i),
    .req_i (lb_req),
    .rd_o  (lb_rd)
  );

  ipc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_valid_i    (s_axis_tvalid),
    .s_ready_o    (s_axis_tready),
    .s_kind_i     (s_axis_tuser[0]),
    .s_pixel_i    (s_axis_tdata[PIX_W-1:0]),
    .m_valid_o    (m_axis_tvalid),
    .m_ready_i    (m_axis_tready),
    .m_pixel_o    (m_axis_tdata[PIX_W-1:0]),
    .m_replaced_o (replaced),
    .m_eor_o      (m_axis_tlast),
    .m_eof_o      (eof),
    .cfg_i        (cfg),
    .lb_req_o     (lb_req),
    .lb_rd_i      (lb_rd)
  );

  assign m_axis_tuser = {eof, replaced};

endmodule

`default_nettype wire
